/* sv/bpc_pkg.sv */
// Shared widths and control types for the bounded partition counter.
`default_nettype none

package bpc_pkg;

    localparam int IN_W   = 6;
    localparam int WAYS_W = 21;

    typedef struct packed {
        logic clr_we;
        logic clr_one;
        logic issue;
        logic last;
        logic empty_done;
        logic zero_res;
    } bpc_ctl_t;

endpackage

`default_nettype wire

/* sv/bpc_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none

module bpc_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_a,
    output logic      [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

/* sv/bpc_seq.sv */
// Sequencer: query capture, row clear sweep and the part-size / sum loop.
`default_nettype none

module bpc_seq import bpc_pkg::*; #(
    parameter int MAX_TOTAL = 63,
    localparam int IDX_W = $clog2(MAX_TOTAL + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [IN_W-1:0]  total,
    input  wire logic [IN_W-1:0]  part_limit,
    output logic                  busy,
    output logic      [IDX_W-1:0] clr_addr,
    output logic      [IDX_W-1:0] rd_a,
    output logic      [IDX_W-1:0] rd_b,
    output bpc_ctl_t              ctl
);

    localparam int CMP_W = (IDX_W > IN_W) ? IDX_W : IN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMPTY,
        S_CLEAR,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] m_reg;
    logic [IDX_W-1:0] top_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] j_reg;
    logic             zero_reg;

    logic [CMP_W-1:0] total_ext;
    logic [CMP_W-1:0] lim_ext;
    logic [CMP_W-1:0] m_sat;
    logic [CMP_W-1:0] top_sat;
    logic [IDX_W-1:0] m_in;
    logic [IDX_W-1:0] top_in;
    logic             j_at_m;
    logic             k_at_top;

    always_comb
    begin
        total_ext = CMP_W'(total);
        lim_ext   = CMP_W'(part_limit);
        m_sat     = (total_ext > CMP_W'(MAX_TOTAL)) ? CMP_W'(MAX_TOTAL) : total_ext;
        top_sat   = (lim_ext < m_sat) ? lim_ext : m_sat;
        m_in      = m_sat[IDX_W-1:0];
        top_in    = top_sat[IDX_W-1:0];
    end

    assign j_at_m   = (j_reg == m_reg);
    assign k_at_top = (k_reg == top_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_reg     <= '0;
            top_reg   <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        m_reg    <= m_in;
                        top_reg  <= top_in;
                        zero_reg <= (m_in == '0);
                        j_reg    <= '0;
                        state_reg <= (top_in == '0) ? S_EMPTY : S_CLEAR;
                    end
                end
                S_EMPTY:
                begin
                    state_reg <= S_IDLE;
                end
                S_CLEAR:
                begin
                    if (j_at_m)
                    begin
                        k_reg     <= IDX_W'(1);
                        j_reg     <= IDX_W'(1);
                        state_reg <= S_RUN;
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                S_RUN:
                begin
                    if (j_at_m)
                    begin
                        if (k_at_top)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            k_reg <= k_reg + IDX_W'(1);
                            j_reg <= k_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign clr_addr = j_reg;
    assign rd_a     = j_reg;
    assign rd_b     = j_reg - k_reg;

    always_comb
    begin
        ctl.clr_we     = (state_reg == S_CLEAR);
        ctl.clr_one    = (j_reg == '0);
        ctl.issue      = (state_reg == S_RUN);
        ctl.last       = (state_reg == S_RUN) && j_at_m && k_at_top;
        ctl.empty_done = (state_reg == S_EMPTY);
        ctl.zero_res   = zero_reg;
    end

endmodule

`default_nettype wire

/* sv/bpc_acc.sv */
// Shared adder: row update with forwarding of the last write, result register.
`default_nettype none

module bpc_acc import bpc_pkg::*; #(
    parameter int IDX_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  bpc_ctl_t               ctl,
    input  wire logic [IDX_W-1:0]  clr_addr,
    input  wire logic [IDX_W-1:0]  rd_a,
    input  wire logic [IDX_W-1:0]  rd_b,
    input  wire logic [WAYS_W-1:0] rdata_a,
    input  wire logic [WAYS_W-1:0] rdata_b,
    output logic                   we,
    output logic      [IDX_W-1:0]  waddr,
    output logic      [WAYS_W-1:0] wdata,
    output logic                   done,
    output logic      [WAYS_W-1:0] ways
);

    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic [IDX_W-1:0]  s1_a_reg;
    logic [IDX_W-1:0]  s1_b_reg;
    logic              prev_we_reg;
    logic [IDX_W-1:0]  prev_addr_reg;
    logic [WAYS_W-1:0] prev_data_reg;
    logic              done_reg;
    logic [WAYS_W-1:0] ways_reg;

    logic [WAYS_W-1:0] val_a;
    logic [WAYS_W-1:0] val_b;
    logic [WAYS_W-1:0] sum;

    // the RAM read sampled alongside last cycle's write sees old data
    always_comb
    begin
        val_a = (prev_we_reg && prev_addr_reg == s1_a_reg) ? prev_data_reg : rdata_a;
        val_b = (prev_we_reg && prev_addr_reg == s1_b_reg) ? prev_data_reg : rdata_b;
        sum   = val_a + val_b;
    end

    always_comb
    begin
        if (s1_valid_reg)
        begin
            we    = 1'b1;
            waddr = s1_a_reg;
            wdata = sum;
        end
        else
        begin
            we    = ctl.clr_we;
            waddr = clr_addr;
            wdata = WAYS_W'(ctl.clr_one);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            prev_we_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.issue;
            s1_last_reg  <= ctl.last;
            prev_we_reg  <= we;
            done_reg     <= (s1_valid_reg && s1_last_reg) || ctl.empty_done;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg      <= rd_a;
        s1_b_reg      <= rd_b;
        prev_addr_reg <= waddr;
        prev_data_reg <= wdata;
        if (ctl.empty_done)
        begin
            ways_reg <= WAYS_W'(ctl.zero_res);
        end
        else if (s1_valid_reg && s1_last_reg)
        begin
            ways_reg <= sum;
        end
    end

    assign done = done_reg;
    assign ways = ways_reg;

endmodule

`default_nettype wire

/* sv/bounded_partition_counter_core.sv */
// Top level of the bounded partition counter.
//
//   channel  | handshake                | fields
//   ---------+--------------------------+------------------------
//   query    | start, busy (in when !busy) | total, part_limit
//   result   | done (one-cycle strobe)  | ways
//
// An item with m = min(total, MAX_TOTAL) and t = min(part_limit, m) first
// clears row entries 0..m, then for each k = 1..t adds row[j - k] into
// row[j] for j = k..m. One row update per cycle goes through the shared
// adder and the two-read RAM. t = 0 skips both for the empty state.
// Reset clears sequencer and adder control; the row is cleared per item.
// done pulses for one cycle and is not held off by the receiver.
`default_nettype none

module bounded_partition_counter_core import bpc_pkg::*; #(
    parameter int MAX_TOTAL = 63
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [IN_W-1:0]   total,
    input  wire logic [IN_W-1:0]   part_limit,
    output logic                   busy,
    output logic                   done,
    output logic      [WAYS_W-1:0] ways
);

    localparam int DEPTH = MAX_TOTAL + 1;
    localparam int IDX_W = $clog2(DEPTH);

    bpc_ctl_t          ctl;
    logic [IDX_W-1:0]  clr_addr;
    logic [IDX_W-1:0]  rd_a;
    logic [IDX_W-1:0]  rd_b;
    logic [WAYS_W-1:0] rdata_a;
    logic [WAYS_W-1:0] rdata_b;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WAYS_W-1:0] wdata;

    bpc_seq #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .total      (total),
        .part_limit (part_limit),
        .busy       (busy),
        .clr_addr   (clr_addr),
        .rd_a       (rd_a),
        .rd_b       (rd_b),
        .ctl        (ctl)
    );

    bpc_ram #(
        .WIDTH (WAYS_W),
        .DEPTH (DEPTH)
    ) u_row (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    bpc_acc #(
        .IDX_W (IDX_W)
    ) u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .clr_addr (clr_addr),
        .rd_a     (rd_a),
        .rd_b     (rd_b),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b),
        .we       (we),
        .waddr    (waddr),
        .wdata    (wdata),
        .done     (done),
        .ways     (ways)
    );

endmodule

`default_nettype wire

/* sv/bpc_chk.sv */
// Port-level checker for the bounded partition counter, bound to the top level.
`default_nettype none

module bpc_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("item finished without a result");

endmodule

bind bounded_partition_counter_core bpc_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire

/* verif/bounded_partition_counter_core_test.sv */
// Testbench for bounded_partition_counter_core: partition-count queries checked against a table model.
`timescale 1ns / 1ps

module bounded_partition_counter_core_test;
    import bpc_pkg::*;

    localparam int MAX_TOTAL  = 63;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic [IN_W-1:0]   total;
    logic [IN_W-1:0]   part_limit;
    logic              busy;
    logic              done;
    logic [WAYS_W-1:0] ways;

    logic [WAYS_W-1:0] ways_due[$];
    int                fail_count;
    int                idle_pct;
    int                quiet_cycles;

    bounded_partition_counter_core #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .total      (total),
        .part_limit (part_limit),
        .busy       (busy),
        .done       (done),
        .ways       (ways)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Partitions of m into at most n parts, via the row of counts by sum.
    function automatic logic [WAYS_W-1:0] partition_ways(input logic [IN_W-1:0] m_in,
                                                         input logic [IN_W-1:0] n_in);
        longint unsigned row [0:MAX_TOTAL];
        int              m;
        int              top;
        m = m_in;
        if (m > MAX_TOTAL)
            m = MAX_TOTAL;
        top = (n_in < m) ? n_in : m;
        for (int j = 0; j <= MAX_TOTAL; j++)
            row[j] = 0;
        row[0] = 1;
        for (int k = 1; k <= top; k++)
            for (int j = k; j <= m; j++)
                row[j] += row[j - k];
        return row[m][WAYS_W-1:0];
    endfunction

    // Offer one query; start may drop at random while waiting for acceptance.
    task automatic send_query(input logic [IN_W-1:0] m, input logic [IN_W-1:0] n);
        logic offered;
        logic taken;
        total      <= m;
        part_limit <= n;
        taken = 1'b0;
        while (!taken)
        begin
            offered = ($urandom_range(99) >= idle_pct);
            start <= offered;
            @(posedge clk);
            if (offered && !busy)
            begin
                ways_due.push_back(partition_ways(m, n));
                taken = 1'b1;
            end
        end
    endtask

    task automatic drain_results;
        start <= 1'b0;
        @(posedge clk);
        while (ways_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_field_extremes;
        send_query(6'd0, 6'd1);
        send_query(6'd0, 6'd63);
        send_query(6'd1, 6'd1);
        send_query(6'd63, 6'd63);
        send_query(6'd63, 6'd1);
        send_query(6'd63, 6'd2);
        send_query(6'd63, 6'd62);
        send_query(6'd62, 6'd63);
        send_query(6'd32, 6'd32);
        send_query(6'd31, 6'd16);
        send_query(6'd42, 6'd21);
        send_query(6'd10, 6'd3);
        send_query(6'd10, 6'd10);
    endtask

    task automatic test_zero_part_limit;
        send_query(6'd0, 6'd0);
        send_query(6'd5, 6'd0);
        send_query(6'd63, 6'd0);
        send_query(6'd1, 6'd0);
    endtask

    task automatic test_limit_above_total;
        send_query(6'd1, 6'd63);
        send_query(6'd5, 6'd6);
        send_query(6'd10, 6'd63);
        send_query(6'd20, 6'd40);
    endtask

    // Mostly small totals to keep the run short; a quarter span the full field.
    task automatic test_random_queries(input int count, input int pct);
        logic [IN_W-1:0] m;
        logic [IN_W-1:0] n;
        int              pick;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                m = IN_W'($urandom_range(63));
            else
                m = IN_W'($urandom_range(20));
            pick = $urandom_range(19);
            if (pick < 2)
                n = '0;
            else if (pick < 11)
                n = IN_W'($urandom_range(1, (m == 0) ? 1 : m));
            else
                n = IN_W'($urandom_range(1, 63));
            send_query(m, n);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (ways_due.size() == 0)
            begin
                $error("ways: unexpected result, actual %0d", ways);
                fail_count++;
            end
            else
            begin
                if (ways !== ways_due[0])
                begin
                    $error("ways: expected %0d, actual %0d", ways_due[0], ways);
                    fail_count++;
                end
                void'(ways_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        total        = '0;
        part_limit   = '0;
        fail_count   = 0;
        idle_pct     = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes;
        test_zero_part_limit;
        test_limit_above_total;
        drain_results;

        test_random_queries(90, 32);
        drain_results;
        test_random_queries(90, 53);
        drain_results;
        test_random_queries(90, 0);
        drain_results;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && ways_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
